@@ rtl/core/reverse_stream_in_groups_of_k_unit_macros.svh @@
// Assertion macros shared by the group-reversal RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef REVERSE_STREAM_IN_GROUPS_OF_K_UNIT_MACROS_SVH
`define REVERSE_STREAM_IN_GROUPS_OF_K_UNIT_MACROS_SVH

// Property must hold at every clock outside reset.
`define RSK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define RSK_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/core/rsk_pkg.sv @@
// Shared types and constants for the group-reversal unit.
// No dependencies; used by every module in rtl/core except rsk_ram.
package rsk_pkg;

  localparam int unsigned MAX_GROUP_DEF  = 16;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned GROUP_SIZE_W   = 5;
  localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RST = 5'd3;

  // Group length field in a descriptor; wide enough for any MaxGroup up to 127.
  localparam int unsigned DESC_CNT_W = 7;

  typedef logic [DESC_CNT_W-1:0] desc_cnt_t;

  // One completed group handed from the front end to the back end.
  typedef struct packed {
    logic      bank;
    desc_cnt_t count;
    logic      reverse;
    logic      eol;
  } desc_t;

  // Back end returns a buffer bank once its last read is issued.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

@@ rtl/core/rsk_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsk_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/rsk_desc_fifo.sv @@
// Two-entry queue of group descriptors between front and back end.
// Depends on rsk_pkg and the assertion macro header.
`include "reverse_stream_in_groups_of_k_unit_macros.svh"

module rsk_desc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rsk_pkg::desc_t desc_i,
  output logic          full_o,
  input  logic          pop_i,
  output rsk_pkg::desc_t desc_o,
  output logic          empty_o
);

  rsk_pkg::desc_t ent_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign desc_o  = ent_q[rd_ptr_q];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // descriptor storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= desc_i;
    end
  end

  // bank ownership keeps at most two groups outstanding
  `RSK_NEVER(a_desc_overflow, push_i && full_o, "descriptor pushed into full queue")
  `RSK_NEVER(a_desc_underflow, pop_i && empty_o, "descriptor popped from empty queue")

endmodule

@@ rtl/core/rsk_front.sv @@
// Front end: takes requests, writes elements into the ping-pong buffer and
// closes groups into descriptors. Depends on rsk_pkg and the macro header.
`include "reverse_stream_in_groups_of_k_unit_macros.svh"

module rsk_front #(
  parameter int unsigned MaxGroup = rsk_pkg::MAX_GROUP_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  output logic                                  full_o,
  input  logic signed [rsk_pkg::VALUE_W-1:0]    value_i,
  input  logic                                  end_of_list_i,
  input  logic                                  group_size_we_i,
  input  logic [rsk_pkg::GROUP_SIZE_W-1:0]      group_size_i,
  output logic                                  ram_we_o,
  output logic [$clog2(2*MaxGroup)-1:0]         ram_waddr_o,
  output logic [rsk_pkg::VALUE_W-1:0]           ram_wdata_o,
  output logic                                  desc_push_o,
  output rsk_pkg::desc_t                        desc_o,
  input  rsk_pkg::release_t                     release_i
);

  localparam int unsigned CntW  = $clog2(MaxGroup + 1);
  localparam int unsigned AddrW = $clog2(2 * MaxGroup);

  logic [rsk_pkg::GROUP_SIZE_W-1:0] group_size_q;
  logic [CntW-1:0]                  fill_cnt_q, fill_cnt_d;
  logic                             fill_bank_q, fill_bank_d;
  logic [1:0]                       busy_q, busy_d;
  logic [CntW-1:0]                  k_eff;
  logic [CntW-1:0]                  cnt_inc;
  logic                             accept;
  logic                             grp_full;
  logic                             flush;

  // effective group length: zero acts as one, large values clamp
  always_comb begin
    if (group_size_q == '0) begin
      k_eff = CntW'(1);
    end else if (int'(group_size_q) > int'(MaxGroup)) begin
      k_eff = CntW'(MaxGroup);
    end else begin
      k_eff = CntW'(group_size_q);
    end
  end

  // input handshake: stall while the bank being filled is still being read
  assign full_o   = busy_q[fill_bank_q];
  assign accept   = push_i && !full_o;
  assign cnt_inc  = fill_cnt_q + CntW'(1);
  assign grp_full = (cnt_inc >= k_eff);
  assign flush    = accept && (grp_full || end_of_list_i);

  // buffer write
  assign ram_we_o    = accept;
  assign ram_waddr_o = (fill_bank_q ? AddrW'(MaxGroup) : AddrW'(0)) + AddrW'(fill_cnt_q);
  assign ram_wdata_o = value_i;

  // descriptor for a closed group
  assign desc_push_o     = flush;
  assign desc_o.bank     = fill_bank_q;
  assign desc_o.count    = rsk_pkg::desc_cnt_t'(cnt_inc);
  assign desc_o.reverse  = grp_full;
  assign desc_o.eol      = end_of_list_i;

  // fill position, bank select and bank ownership
  always_comb begin
    fill_cnt_d  = fill_cnt_q;
    fill_bank_d = fill_bank_q;
    busy_d      = busy_q;
    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end
    if (flush) begin
      fill_cnt_d          = '0;
      fill_bank_d         = ~fill_bank_q;
      busy_d[fill_bank_q] = 1'b1;
    end else if (accept) begin
      fill_cnt_d = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= rsk_pkg::GROUP_SIZE_RST;
      fill_cnt_q   <= '0;
      fill_bank_q  <= 1'b0;
      busy_q       <= '0;
    end else begin
      if (group_size_we_i) begin
        group_size_q <= group_size_i;
      end
      fill_cnt_q  <= fill_cnt_d;
      fill_bank_q <= fill_bank_d;
      busy_q      <= busy_d;
    end
  end

  `RSK_ASSERT(a_release_busy, release_i.valid |-> busy_q[release_i.bank],
              "bank released that was not owned by the back end")
  `RSK_ASSERT(a_fill_bound, fill_cnt_q < CntW'(MaxGroup),
              "fill count reached buffer depth without a flush")

endmodule

@@ rtl/core/rsk_back.sv @@
// Back end: reads each closed group from the buffer in the requested order and
// queues the results for the output side. Depends on rsk_pkg and the macro header.
`include "reverse_stream_in_groups_of_k_unit_macros.svh"

module rsk_back #(
  parameter int unsigned MaxGroup = rsk_pkg::MAX_GROUP_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  desc_empty_i,
  input  rsk_pkg::desc_t                        desc_i,
  output logic                                  desc_pop_o,
  output logic                                  ram_re_o,
  output logic [$clog2(2*MaxGroup)-1:0]         ram_raddr_o,
  input  logic [rsk_pkg::VALUE_W-1:0]           ram_rdata_i,
  output rsk_pkg::release_t                     release_o,
  output logic                                  empty_o,
  input  logic                                  pop_i,
  output logic signed [rsk_pkg::VALUE_W-1:0]    value_res_o,
  output logic                                  run_last_o,
  output logic                                  list_last_o
);

  localparam int unsigned CntW     = $clog2(MaxGroup + 1);
  localparam int unsigned AddrW    = $clog2(2 * MaxGroup);
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OPtrW    = $clog2(OutDepth);
  localparam int unsigned OCntW    = $clog2(OutDepth + 1);

  typedef enum logic [1:0] {
    BkIdle = 2'b01,
    BkRun  = 2'b10
  } bk_state_e;

  bk_state_e      state_q, state_d;
  rsk_pkg::desc_t cur_q, cur_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cur_cnt;
  logic [CntW-1:0] src;
  logic            space;
  logic            issue;
  logic            last_issue;

  logic            rd_vld_q;
  logic            rd_run_last_q;
  logic            rd_list_last_q;

  logic [rsk_pkg::VALUE_W-1:0] ov_value_q [OutDepth];
  logic                        ov_run_q   [OutDepth];
  logic                        ov_list_q  [OutDepth];
  logic [OPtrW-1:0]            owr_ptr_q, ord_ptr_q;
  logic [OCntW-1:0]            ocnt_q, ocnt_d;
  logic                        opop;

  // issue a read only when the output queue has room for it
  assign cur_cnt    = CntW'(cur_q.count);
  assign space      = (ocnt_q + OCntW'(rd_vld_q)) < OCntW'(OutDepth);
  assign issue      = (state_q == BkRun) && space;
  assign last_issue = issue && ((idx_q + CntW'(1)) == cur_cnt);
  assign src        = cur_q.reverse ? (cur_cnt - CntW'(1) - idx_q) : idx_q;

  assign ram_re_o    = issue;
  assign ram_raddr_o = (cur_q.bank ? AddrW'(MaxGroup) : AddrW'(0)) + AddrW'(src);

  assign release_o.valid = last_issue;
  assign release_o.bank  = cur_q.bank;

  // group sequencer
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    desc_pop_o = 1'b0;
    unique case (state_q)
      BkIdle: begin
        if (!desc_empty_i) begin
          desc_pop_o = 1'b1;
          cur_d      = desc_i;
          idx_d      = '0;
          state_d    = BkRun;
        end
      end
      BkRun: begin
        if (last_issue) begin
          if (!desc_empty_i) begin
            desc_pop_o = 1'b1;
            cur_d      = desc_i;
            idx_d      = '0;
          end else begin
            state_d = BkIdle;
          end
        end else if (issue) begin
          idx_d = idx_q + CntW'(1);
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BkIdle;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rd_vld_q <= issue;
    end
  end

  // descriptor and read-side marks travel alongside the RAM read
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (issue) begin
      rd_run_last_q  <= last_issue;
      rd_list_last_q <= last_issue && cur_q.eol;
    end
  end

  // output queue
  assign empty_o     = (ocnt_q == '0);
  assign opop        = pop_i && !empty_o;
  assign value_res_o = ov_value_q[ord_ptr_q];
  assign run_last_o  = ov_run_q[ord_ptr_q];
  assign list_last_o = ov_list_q[ord_ptr_q];
  assign ocnt_d      = ocnt_q + OCntW'(rd_vld_q) - OCntW'(opop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_ptr_q <= '0;
      ord_ptr_q <= '0;
      ocnt_q    <= '0;
    end else begin
      if (rd_vld_q) begin
        owr_ptr_q <= owr_ptr_q + OPtrW'(1);
      end
      if (opop) begin
        ord_ptr_q <= ord_ptr_q + OPtrW'(1);
      end
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      ov_value_q[owr_ptr_q] <= ram_rdata_i;
      ov_run_q[owr_ptr_q]   <= rd_run_last_q;
      ov_list_q[owr_ptr_q]  <= rd_list_last_q;
    end
  end

  `RSK_ASSERT(a_out_bound, ocnt_q <= OCntW'(OutDepth), "output queue overflow")
  `RSK_ASSERT(a_idx_bound, (state_q == BkRun) |-> (idx_q < cur_cnt),
              "read index ran past the group length")

endmodule

@@ rtl/core/reverse_stream_in_groups_of_k_unit.sv @@
// Reverses a stream in groups of group_size elements: each full group leaves in
// reversed order, and a partial group closed by end_of_list leaves in arrival
// order. The buffer holds two banks of MaxGroup entries, so filling one group
// overlaps the readout of the one before; an element is taken in any cycle in
// which the bank being filled is free. Readout runs at one result per cycle
// through the single buffer read port while the result queue has room. A
// closed group is queued as a descriptor, taken by the back end and read from
// the RAM into the result queue. full is raised when both banks still hold
// groups waiting to be read out. A stalled pop fills the four-entry result
// queue first and then both banks.
// Depends on rsk_pkg, rsk_ram, rsk_desc_fifo, rsk_front and rsk_back.
module reverse_stream_in_groups_of_k_unit #(
  parameter int unsigned MaxGroup = rsk_pkg::MAX_GROUP_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // element requests
  input  logic                               push,
  output logic                               full,
  input  logic signed [rsk_pkg::VALUE_W-1:0] value_i,
  input  logic                               end_of_list_i,
  // result requests
  output logic                               empty,
  input  logic                               pop,
  output logic signed [rsk_pkg::VALUE_W-1:0] value_res_o,
  output logic                               run_last_o,
  output logic                               list_last_o,
  // group length register
  input  logic                               group_size_we_i,
  input  logic [rsk_pkg::GROUP_SIZE_W-1:0]   group_size_i
);

  localparam int unsigned AddrW = $clog2(2 * MaxGroup);

  logic                        ram_we;
  logic [AddrW-1:0]            ram_waddr;
  logic [rsk_pkg::VALUE_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [AddrW-1:0]            ram_raddr;
  logic [rsk_pkg::VALUE_W-1:0] ram_rdata;

  logic                        dq_push, dq_full, dq_pop, dq_empty;
  rsk_pkg::desc_t              dq_in, dq_out;
  rsk_pkg::release_t           bank_release;

  rsk_front #(
    .MaxGroup(MaxGroup)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .value_i        (value_i),
    .end_of_list_i  (end_of_list_i),
    .group_size_we_i(group_size_we_i),
    .group_size_i   (group_size_i),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .desc_push_o    (dq_push),
    .desc_o         (dq_in),
    .release_i      (bank_release)
  );

  rsk_desc_fifo u_desc_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (dq_push),
    .desc_i (dq_in),
    .full_o (dq_full),
    .pop_i  (dq_pop),
    .desc_o (dq_out),
    .empty_o(dq_empty)
  );

  rsk_ram #(
    .Width(rsk_pkg::VALUE_W),
    .Depth(2 * MaxGroup)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rsk_back #(
    .MaxGroup(MaxGroup)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_empty_i(dq_empty),
    .desc_i      (dq_out),
    .desc_pop_o  (dq_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .release_o   (bank_release),
    .empty_o     (empty),
    .pop_i       (pop),
    .value_res_o (value_res_o),
    .run_last_o  (run_last_o),
    .list_last_o (list_last_o)
  );

  // the descriptor queue never fills: each queued group owns a bank
  logic unused_dq_full;
  assign unused_dq_full = dq_full;

endmodule

@@ tb/reverse_stream_in_groups_of_k_unit_tb.sv @@
// Testbench for reverse_stream_in_groups_of_k_unit: directed and random element lists,
// checked against a predictor of the group reversal. Depends on rsk_pkg and the unit.
module reverse_stream_in_groups_of_k_unit_tb;

  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct packed {
    logic signed [rsk_pkg::VALUE_W-1:0] value;
    logic                               run_last;
    logic                               list_last;
  } elem_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                push;
  logic                                full;
  logic signed [rsk_pkg::VALUE_W-1:0]  value_i;
  logic                                end_of_list_i;
  logic                                empty;
  logic                                pop;
  logic signed [rsk_pkg::VALUE_W-1:0]  value_res_o;
  logic                                run_last_o;
  logic                                list_last_o;
  logic                                group_size_we_i;
  logic [rsk_pkg::GROUP_SIZE_W-1:0]    group_size_i;

  // predictor state: the held group and the group length register
  logic [rsk_pkg::VALUE_W-1:0]         held_buf [rsk_pkg::MAX_GROUP_DEF];
  int unsigned                         held_count;
  logic [rsk_pkg::GROUP_SIZE_W-1:0]    group_len_q;
  elem_t                               reversed_q[$];

  int  mismatches;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_req;
  logic rx_stall;

  reverse_stream_in_groups_of_k_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .value_i         (value_i),
    .end_of_list_i   (end_of_list_i),
    .empty           (empty),
    .pop             (pop),
    .value_res_o     (value_res_o),
    .run_last_o      (run_last_o),
    .list_last_o     (list_last_o),
    .group_size_we_i (group_size_we_i),
    .group_size_i    (group_size_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // fixed run limit
  initial begin
    #2000000;
    $display("reverse_stream_in_groups_of_k_unit: mismatch");
    $finish;
  end

  // store one element, emit the group once it is complete or the list ends
  task automatic reverse_predict(input logic [rsk_pkg::VALUE_W-1:0] v, input logic eol);
    int unsigned k;
    int unsigned n;
    int unsigned i;
    bit flip;
    elem_t r;
    k = group_len_q;
    if (k == 0) k = 1;
    if (k > rsk_pkg::MAX_GROUP_DEF) k = rsk_pkg::MAX_GROUP_DEF;
    if (held_count < rsk_pkg::MAX_GROUP_DEF) begin
      held_buf[held_count] = v;
      held_count++;
    end
    if (held_count >= k) flip = 1'b1;
    else if (eol) flip = 1'b0;
    else return;
    n = held_count;
    for (i = 0; i < n; i++) begin
      r.value     = held_buf[flip ? (n - 1 - i) : i];
      r.run_last  = (i + 1 == n);
      r.list_last = (i + 1 == n) && eol;
      reversed_q.push_back(r);
    end
    held_count = 0;
  endtask

  // offer one element request, with random sender gaps before it
  task automatic send_element(input logic signed [rsk_pkg::VALUE_W-1:0] v, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    value_i       <= v;
    end_of_list_i <= eol;
    do @(posedge clk_i); while (full);
    reverse_predict(v, eol);
  endtask

  // wait for every expected result, then for any group still in flight
  task automatic wait_until_idle();
    push <= 1'b0;
    while (reversed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_group_size(input logic [rsk_pkg::GROUP_SIZE_W-1:0] k);
    group_size_we_i <= 1'b1;
    group_size_i    <= k;
    @(posedge clk_i);
    group_size_we_i <= 1'b0;
    group_len_q = k;
  endtask

  function automatic logic signed [rsk_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return ($urandom_range(1) != 0) ? 32'sh0 : -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // reset length 3: one reversed group, then a partial group kept in order
  task automatic test_reset_length();
    send_element(32'sh7FFF_FFFF, 1'b0);
    send_element(32'sh8000_0000, 1'b0);
    send_element(32'sh5555_5555, 1'b0);
    send_element(32'shAAAA_AAAA, 1'b0);
    send_element(-32'sd1, 1'b1);
    wait_until_idle();
  endtask

  // length 0 acts as 1: each element passes on its own
  task automatic test_zero_length();
    set_group_size('0);
    send_element(32'sh0, 1'b0);
    send_element(32'sd1, 1'b1);
    wait_until_idle();
  endtask

  // all-ones length saturates to the bank size; full group closes on list end
  task automatic test_saturated_length();
    int i;
    set_group_size('1);
    for (i = 0; i < rsk_pkg::MAX_GROUP_DEF; i++)
      send_element(pick_value(), i == rsk_pkg::MAX_GROUP_DEF - 1);
    wait_until_idle();
  endtask

  // length lowered while a group holds three of four elements: the next element flushes it reversed
  task automatic test_shrink_mid_group();
    set_group_size(5'd4);
    send_element(32'sd10, 1'b0);
    send_element(32'sd20, 1'b0);
    send_element(32'sd30, 1'b0);
    wait_until_idle();
    set_group_size(5'd2);
    send_element(32'sd40, 1'b0);
    wait_until_idle();
  endtask

  // receiver holds off long enough for both banks to fill and push to stall
  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_group_size(5'd16);
    hold_req = 1'b1;
    for (i = 0; i < 48; i++) send_element(pick_value(), i == 47);
    wait_until_idle();
  endtask

  // random lists at random lengths; some are cut short so a write lands mid-group
  task automatic test_random_lists(input int n_items, input int tx_pct, input int rx_pct);
    int sent;
    int len;
    int i;
    bit cut;
    logic [rsk_pkg::GROUP_SIZE_W-1:0] k;
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0:       k = 5'd1;
        1:       k = 5'd16;
        2:       k = 5'($urandom_range(0, 31));
        default: k = 5'($urandom_range(2, 8));
      endcase
      set_group_size(k);
      len = $urandom_range(1, 24);
      cut = ($urandom_range(7) == 0);
      for (i = 0; i < len; i++) send_element(pick_value(), (i == len - 1) && !cut);
      sent += len;
      wait_until_idle();
    end
  endtask

  // receiver stall window, counted here
  initial begin
    rx_stall <= 1'b0;
    forever begin
      wait (hold_req);
      rx_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      rx_stall <= 1'b0;
      hold_req = 1'b0;
    end
  end

  // result check and pop drive
  initial begin : check_results
    elem_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (reversed_q.size() == 0) begin
          $error("unexpected result: value_res %0d", value_res_o);
          mismatches++;
        end else begin
          want = reversed_q.pop_front();
          if (value_res_o !== want.value) begin
            $error("value_res: expected %0d, got %0d", want.value, value_res_o);
            mismatches++;
          end
          if (run_last_o !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, run_last_o);
            mismatches++;
          end
          if (list_last_o !== want.list_last) begin
            $error("list_last: expected %0b, got %0b", want.list_last, list_last_o);
            mismatches++;
          end
        end
      end
      pop <= !rx_stall && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // main sequence
  initial begin
    mismatches      = 0;
    held_count      = 0;
    group_len_q     = rsk_pkg::GROUP_SIZE_RST;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    hold_req        = 1'b0;
    rst_ni          <= 1'b0;
    push            <= 1'b0;
    value_i         <= '0;
    end_of_list_i   <= 1'b0;
    pop             <= 1'b0;
    group_size_we_i <= 1'b0;
    group_size_i    <= rsk_pkg::GROUP_SIZE_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_length();
    test_zero_length();
    test_saturated_length();
    test_shrink_mid_group();
    test_backpressure();
    test_random_lists(55, 37, 81);
    test_random_lists(55, 81, 37);
    test_random_lists(55, 0, 0);
    wait_until_idle();

    if (mismatches == 0) begin
      $display("reverse_stream_in_groups_of_k_unit: match");
    end else begin
      $display("reverse_stream_in_groups_of_k_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rsk_pkg.sv
rtl/core/rsk_ram.sv
rtl/core/rsk_desc_fifo.sv
rtl/core/rsk_front.sv
rtl/core/rsk_back.sv
rtl/core/reverse_stream_in_groups_of_k_unit.sv
tb/reverse_stream_in_groups_of_k_unit_tb.sv
